@@ rtl/botf_pkg.sv @@
// Package for the BIOS time-of-day formatter: field widths, function codes,
// request kinds and the two-digit BCD helper. No dependencies.
`timescale 1ns / 1ps

package botf_pkg;

  localparam int unsigned TICKS_W = 22;  // 1573040 ticks per day, plus out-of-range headroom

  localparam logic [7:0] FN_TICKS     = 8'd0;
  localparam logic [7:0] FN_SET_TICKS = 8'd1;
  localparam logic [7:0] FN_TIME      = 8'd2;
  localparam logic [7:0] FN_SET_TIME  = 8'd3;
  localparam logic [7:0] FN_DATE      = 8'd4;
  localparam logic [7:0] FN_SET_DATE  = 8'd5;
  localparam logic [7:0] FN_SET_ALARM = 8'd6;
  localparam logic [7:0] FN_CLR_ALARM = 8'd7;

  typedef enum logic [2:0] {
    KIND_TICKS,
    KIND_TIME,
    KIND_DATE,
    KIND_REFUSE,
    KIND_NONE
  } kind_t;

  // Two packed BCD digits; values above 99 saturate to 99.
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [6:0]  s;
    logic [14:0] t;
    logic [3:0]  tens;
    logic [6:0]  ones;
    s    = (v > 7'd99) ? 7'd99 : v;
    t    = 15'(s) * 15'd205;  // floor(s / 10) = (s * 205) >> 11 for s < 100
    tens = t[14:11];
    ones = s - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

@@ rtl/botf_ticks.sv @@
// Tick-count datapath: seconds since midnight and microseconds to 18.2 Hz ticks.
// Three register stages, constant reciprocal multiplies. Uses botf_pkg.
`timescale 1ns / 1ps

module botf_ticks import botf_pkg::*; (
  input  logic               clk,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  logic [19:0]        microsecond,
  output logic [TICKS_W-1:0] ticks
);

  // x / 1080 = (x >> 3) / 135; x / 10^7 = (x >> 7) / 78125
  localparam longint unsigned M135_FULL   = ((64'd1 << 37) + 64'd134) / 64'd135;
  localparam longint unsigned M78125_FULL = ((64'd1 << 38) + 64'd78124) / 64'd78125;
  localparam logic [29:0] M135   = 30'(M135_FULL);
  localparam logic [21:0] M78125 = 22'(M78125_FULL);

  logic [16:0] secs_r;
  logic [27:0] us182_r;
  logic [31:0] scaled_r;
  logic [42:0] frac_prod_r;
  logic [58:0] whole_prod_r;
  logic [4:0]  frac_r;

  always_ff @(posedge clk) begin
    // stage A
    secs_r  <= 17'(second) + 17'(minute) * 17'd60 + 17'(hour) * 17'd3600;
    us182_r <= 28'(microsecond) * 28'd182;
    // stage B
    scaled_r    <= 32'(secs_r) * 32'd19663;
    frac_prod_r <= 43'(us182_r[27:7]) * 43'(M78125);
    // stage C
    whole_prod_r <= 59'(scaled_r[31:3]) * 59'(M135);
    frac_r       <= frac_prod_r[42:38];
  end

  assign ticks = whole_prod_r[58:37] + TICKS_W'(frac_r);

endmodule

@@ rtl/bios_time_of_day_formatter_top.sv @@
// Top level of the BIOS time-of-day formatter (INT 1Ah functions 0, 2, 4).
// Uses botf_pkg and botf_ticks.
`timescale 1ns / 1ps
//
//  channel   handshake          payload
//  request   start / busy       in_cmd, in_hour ... in_weekday
//  result    out_valid strobe   out_cx_word ... out_carry
//
// A request taken with start passes the stage-1, stage-2, stage-3 and output
// registers before its result strobe. One request per cycle, busy is always low.
// Reset (rst_n low, synchronous) flushes the valid bits; requests in flight
// are dropped. Results cannot be held off, so the pipeline never stalls.

module bios_time_of_day_formatter_top import botf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_cmd,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic [19:0] in_microsecond,
  input  logic [7:0]  in_years_since_1900,
  input  logic [3:0]  in_month_index,
  input  logic [4:0]  in_day_of_month,
  input  logic [2:0]  in_weekday,
  output logic        out_valid,
  output logic [15:0] out_cx_word,
  output logic [15:0] out_dx_word,
  output logic [7:0]  out_al_byte,
  output logic        out_al_written,
  output logic        out_words_written,
  output logic        out_carry
);

  localparam logic [16:0] M625 = 17'd107375;  // ceil(2^26 / 625)

  logic [TICKS_W-1:0] ticks;

  logic [3:0] vld_r;
  kind_t      kind1_r, kind2_r, kind3_r;
  logic [15:0] cx1_r, cx2_r, cx3_r;
  logic [7:0]  dxh1_r, dxh2_r, dxh3_r;
  logic [7:0]  dxl1_r, dxl2_r, dxl3_r;
  logic [7:0]  al1_r, al2_r, al3_r;
  logic [32:0] hprod_r;
  logic [6:0]  hund_r;

  kind_t       kind_nxt;
  logic [15:0] cx_nxt;
  logic [7:0]  dxh_nxt, dxl_nxt, al_nxt;
  logic [1:0]  cent;
  logic [7:0]  yr_mod;

  logic [15:0] cx_out_nxt, dx_out_nxt;
  logic [7:0]  al_out_nxt;
  logic        alw_nxt, ww_nxt, cy_nxt;
  logic [15:0] out_cx_r, out_dx_r;
  logic [7:0]  out_al_r;
  logic        out_alw_r, out_ww_r, out_cy_r;

  assign busy = 1'b0;

  botf_ticks u_ticks (
    .clk         (clk),
    .hour        (in_hour),
    .minute      (in_minute),
    .second      (in_second),
    .microsecond (in_microsecond),
    .ticks       (ticks)
  );

  // stage 1 decode and BCD of the direct fields
  always_comb begin
    cent   = (in_years_since_1900 >= 8'd200) ? 2'd2 :
             (in_years_since_1900 >= 8'd100) ? 2'd1 : 2'd0;
    yr_mod = in_years_since_1900 - 8'(cent) * 8'd100;
    cx_nxt  = '0;
    dxh_nxt = '0;
    dxl_nxt = '0;
    al_nxt  = '0;
    unique case (in_cmd) inside
      FN_TICKS: kind_nxt = KIND_TICKS;
      FN_TIME: begin
        kind_nxt = KIND_TIME;
        cx_nxt   = {bcd2(7'(in_hour)), bcd2(7'(in_minute))};
        dxh_nxt  = bcd2(7'(in_second));
      end
      FN_DATE: begin
        kind_nxt = KIND_DATE;
        cx_nxt   = {bcd2(7'd19 + 7'(cent)), bcd2(yr_mod[6:0])};
        dxh_nxt  = bcd2(7'(in_month_index) + 7'd1);
        dxl_nxt  = bcd2(7'(in_day_of_month));
        al_nxt   = 8'(in_weekday);
      end
      FN_SET_TICKS, FN_SET_TIME, FN_SET_DATE, FN_SET_ALARM, FN_CLR_ALARM:
        kind_nxt = KIND_REFUSE;
      default: kind_nxt = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    kind1_r <= kind_nxt;
    cx1_r   <= cx_nxt;
    dxh1_r  <= dxh_nxt;
    dxl1_r  <= dxl_nxt;
    al1_r   <= al_nxt;
    // hundredths = usec / 10000 = (usec >> 4) / 625
    hprod_r <= 33'(in_microsecond[19:4]) * 33'(M625);

    kind2_r <= kind1_r;
    cx2_r   <= cx1_r;
    dxh2_r  <= dxh1_r;
    dxl2_r  <= dxl1_r;
    al2_r   <= al1_r;
    hund_r  <= hprod_r[32:26];

    kind3_r <= kind2_r;
    cx3_r   <= cx2_r;
    dxh3_r  <= dxh2_r;
    dxl3_r  <= (kind2_r == KIND_TIME) ? bcd2(hund_r) : dxl2_r;
    al3_r   <= al2_r;
  end

  // stage 4: merge with the tick datapath
  always_comb begin
    cx_out_nxt = '0;
    dx_out_nxt = '0;
    al_out_nxt = '0;
    alw_nxt    = 1'b0;
    ww_nxt     = 1'b0;
    cy_nxt     = 1'b0;
    unique case (kind3_r)
      KIND_TICKS: begin
        cx_out_nxt = 16'(ticks[TICKS_W-1:16]);
        dx_out_nxt = ticks[15:0];
        alw_nxt    = 1'b1;
        ww_nxt     = 1'b1;
      end
      KIND_TIME: begin
        cx_out_nxt = cx3_r;
        dx_out_nxt = {dxh3_r, dxl3_r};
        ww_nxt     = 1'b1;
      end
      KIND_DATE: begin
        cx_out_nxt = cx3_r;
        dx_out_nxt = {dxh3_r, dxl3_r};
        al_out_nxt = al3_r;
        alw_nxt    = 1'b1;
        ww_nxt     = 1'b1;
      end
      KIND_REFUSE: cy_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    out_cx_r  <= cx_out_nxt;
    out_dx_r  <= dx_out_nxt;
    out_al_r  <= al_out_nxt;
    out_alw_r <= alw_nxt;
    out_ww_r  <= ww_nxt;
    out_cy_r  <= cy_nxt;
  end

  assign out_valid         = vld_r[3];
  assign out_cx_word       = out_cx_r;
  assign out_dx_word       = out_dx_r;
  assign out_al_byte       = out_al_r;
  assign out_al_written    = out_alw_r;
  assign out_words_written = out_ww_r;
  assign out_carry         = out_cy_r;

endmodule
